/* rtl/sset_pkg.sv */
package sset_pkg;

   localparam int CAPACITY        = 16;
   localparam int VALUE_WIDTH     = 32;
   localparam int COUNT_WIDTH     = $clog2(CAPACITY + 1);
   localparam int REQ_VALUE_WIDTH = 32;
   localparam int RSP_COUNT_WIDTH = 5;

   typedef logic signed [VALUE_WIDTH-1:0] key_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic    insert;
      logic    remove;
      key_type key;
   } cell_ctrl_type;

endpackage

/* rtl/sset_cell.sv */
module sset_cell (
   input  logic                   clock,
   input  sset_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   left_lt,
   input  sset_pkg::key_type      left_key,
   input  sset_pkg::key_type      right_key,
   output sset_pkg::key_type      key,
   output logic                   lt,
   output logic                   eq
);
   import sset_pkg::*;

   key_type key_ff;
   key_type key_in;

   assign key = key_ff;
   assign lt  = occupied && (key_ff < ctrl.key);
   assign eq  = occupied && (key_ff == ctrl.key);

   always_comb begin
      key_in = key_ff;
      if (ctrl.insert) begin
         // Cells below the insertion point hold; the first cell at or above it
         // takes the new key; the rest move up by one.
         if (!lt) begin
            key_in = left_lt ? ctrl.key : left_key;
         end
      end else if (ctrl.remove) begin
         // Close the gap: every cell at or above the match pulls from the right.
         if (!lt) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

/* rtl/sorted_set_insert_remove_core.sv */
// Sorted set of distinct signed keys, up to CAPACITY entries, kept in ascending
// order in a row of compare cells.
// Request channel (req_valid/req_ready): req_action is add, remove or query;
// req_value is the key. Response channel (rsp_valid/rsp_ready): rsp_success,
// rsp_full_reject (add refused because the set is full) and rsp_count, the
// number of keys held after the transaction. One response per request.
// Every cell compares its key against the request in the cycle the request is
// accepted; the insert or remove shift happens across the whole row at that
// clock edge, and rsp_valid rises in the cycle after acceptance. One
// request is taken per cycle as long as responses are drained.
// The response register is a single stage: while it holds an untaken result,
// req_ready follows rsp_ready, so a stalled receiver stalls the requester.
// Reset empties the set and clears the response valid flag; stored keys are
// not cleared, since slots at or above the count are never read.
module sorted_set_insert_remove_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic signed [sset_pkg::REQ_VALUE_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_success,
   output logic                                  rsp_full_reject,
   output logic [sset_pkg::RSP_COUNT_WIDTH-1:0]  rsp_count
);
   import sset_pkg::*;

   count_type     count_ff;
   count_type     count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          rsp_success_ff;
   logic          rsp_success_in;
   logic          rsp_full_ff;
   logic          rsp_full_in;
   count_type     rsp_count_ff;

   cell_ctrl_type ctrl;
   key_type       req_key;
   action_type    action;
   logic          accept;
   logic          found;
   logic          is_full;

   key_type               cell_key [CAPACITY];
   logic [CAPACITY-1:0]   cell_lt;
   logic [CAPACITY-1:0]   cell_eq;

   assign req_key = VALUE_WIDTH'(req_value);
   assign action  = action_type'(req_action);
   assign accept  = req_valid && req_ready;
   assign found   = |cell_eq;
   assign is_full = (count_ff == count_type'(CAPACITY));

   assign req_ready = !rsp_valid_ff || rsp_ready;

   assign ctrl.key    = req_key;
   assign ctrl.insert = accept && (action == ACT_ADD) && !found && !is_full;
   assign ctrl.remove = accept && (action == ACT_REMOVE) && found;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic    occupied;
      logic    left_lt;
      key_type left_key;
      key_type right_key;

      assign occupied = (count_type'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_lt  = 1'b1;
         assign left_key = req_key;
      end else begin : g_mid
         assign left_lt  = cell_lt[i-1];
         assign left_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      sset_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied),
         .left_lt   (left_lt),
         .left_key  (left_key),
         .right_key (right_key),
         .key       (cell_key[i]),
         .lt        (cell_lt[i]),
         .eq        (cell_eq[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + count_type'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - count_type'(1);
      end
   end

   always_comb begin
      rsp_success_in = 1'b0;
      rsp_full_in    = 1'b0;
      unique case (action)
         ACT_ADD: begin
            rsp_success_in = !found && !is_full;
            rsp_full_in    = !found && is_full;
         end
         ACT_REMOVE: rsp_success_in = found;
         ACT_QUERY:  rsp_success_in = found;
         default: begin
            rsp_success_in = 1'b0;
            rsp_full_in    = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_success_ff <= rsp_success_in;
         rsp_full_ff    <= rsp_full_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_full_reject = rsp_full_ff;
   assign rsp_count       = RSP_COUNT_WIDTH'(rsp_count_ff);

endmodule

/* tb/sv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sset_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         ITEM_TARGET = 1450;
   localparam int         IDLE_LIMIT  = 4000;
   localparam int         POOL_SIZE   = 24;

   typedef logic signed [REQ_VALUE_WIDTH-1:0] req_word_type;

   localparam req_word_type WORD_MIN = {1'b1, {(REQ_VALUE_WIDTH-1){1'b0}}};
   localparam req_word_type WORD_MAX = {1'b0, {(REQ_VALUE_WIDTH-1){1'b1}}};

   typedef struct {
      logic                       success;
      logic                       full_reject;
      logic [RSP_COUNT_WIDTH-1:0] count;
   } set_outcome_type;

   // Mirror of the set contents; predicts one outcome per accepted request.
   class sorted_set_tracker;
      key_type         held_keys[CAPACITY];
      int              held_count;
      set_outcome_type outcomes_due[$];
      int              mismatches;

      function new();
         held_count = 0;
         mismatches = 0;
      endfunction

      function void note_request(logic [1:0] act, req_word_type value);
         key_type         key;
         int              pos;
         bit              found;
         set_outcome_type res;
         key = key_type'(value);
         pos = 0;
         while (pos < held_count && held_keys[pos] < key) pos++;
         found = (pos < held_count) && (held_keys[pos] == key);
         res.success     = 1'b0;
         res.full_reject = 1'b0;
         case (act)
            ACT_ADD: begin
               if (!found) begin
                  if (held_count >= CAPACITY) begin
                     res.full_reject = 1'b1;
                  end else begin
                     for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
                     held_keys[pos] = key;
                     held_count++;
                     res.success = 1'b1;
                  end
               end
            end
            ACT_REMOVE: begin
               if (found) begin
                  for (int i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
                  held_count--;
                  res.success = 1'b1;
               end
            end
            ACT_QUERY: begin
               res.success = found;
            end
            default: begin
            end
         endcase
         res.count = held_count[RSP_COUNT_WIDTH-1:0];
         outcomes_due.push_back(res);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_response(logic ok, logic full, logic [RSP_COUNT_WIDTH-1:0] cnt);
         set_outcome_type want;
         if (outcomes_due.size() == 0) begin
            report($sformatf("response with none outstanding (success %0b count %0d)",
                             ok, cnt));
         end else begin
            want = outcomes_due.pop_front();
            if (ok !== want.success)
               report($sformatf("success %0b, expected %0b", ok, want.success));
            if (full !== want.full_reject)
               report($sformatf("full_reject %0b, expected %0b", full, want.full_reject));
            if (cnt !== want.count)
               report($sformatf("count %0d, expected %0d", cnt, want.count));
         end
      endtask

      function int pending();
         return outcomes_due.size();
      endfunction
   endclass

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_valid  = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_action = ACT_QUERY;
   req_word_type               req_value  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready  = 1'b0;
   logic                       rsp_success;
   logic                       rsp_full_reject;
   logic [RSP_COUNT_WIDTH-1:0] rsp_count;

   logic [7:0]                 stall_phase = '0;
   int                         stall_mode  = 0;
   int                         idle_cycles = 0;
   req_word_type               key_pool[POOL_SIZE];

   sorted_set_tracker sets = new();

   sorted_set_insert_remove_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_success     (rsp_success),
      .rsp_full_reject (rsp_full_reject),
      .rsp_count       (rsp_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Check before noting, so a response can never match the request taken on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sets.check_response(rsp_success, rsp_full_reject, rsp_count);
         if (req_valid && req_ready)
            sets.note_request(req_action, req_value);
      end
   end

   // Receiver: switch stall pattern whenever the low six bits of stall_phase are zero.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase[5:0] == 6'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= (stall_phase[1:0] == 2'd0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Hold valid and payload until the transaction is taken.
   task automatic send_request(input logic [1:0] act, input req_word_type value);
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_off(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Advance one edge first so the last accepted request is already noted.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sets.pending() != 0) @(posedge clock);
   endtask

   function automatic req_word_type pick_key();
      if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return req_word_type'($urandom);
   endfunction

   function automatic logic [1:0] pick_action(input int add_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r >= 95) return ACT_UNUSED;
      if (r < add_pct * 95 / 100) return ACT_ADD;
      return $urandom_range(0, 1) ? ACT_REMOVE : ACT_QUERY;
   endfunction

   initial begin
      int sent;
      int burst;
      int add_pct;
      bit paused;

      key_pool[0] = WORD_MIN;
      key_pool[1] = WORD_MAX;
      key_pool[2] = '0;
      key_pool[3] = -1;
      key_pool[4] = WORD_MIN + 1;
      key_pool[5] = WORD_MAX - 1;
      for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = req_word_type'($urandom);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(ACT_ADD, 0);
      send_request(ACT_ADD, WORD_MAX);
      send_request(ACT_ADD, WORD_MIN);
      send_request(ACT_ADD, -1);
      send_request(ACT_ADD, 0);               // duplicate add
      send_request(ACT_QUERY, WORD_MIN);
      send_request(ACT_QUERY, 5);             // absent
      send_request(ACT_REMOVE, WORD_MIN);     // smallest key
      send_request(ACT_REMOVE, WORD_MIN);     // now absent
      send_request(ACT_UNUSED, 7);
      for (int i = 0; i < CAPACITY - 3; i++) send_request(ACT_ADD, 100 + i);
      send_request(ACT_ADD, 999);             // absent key, set full
      send_request(ACT_ADD, 0);               // present key, set full
      send_request(ACT_REMOVE, WORD_MAX);
      drain_results();

      sent    = 0;
      paused  = 1'b0;
      add_pct = 50;
      while (sent < ITEM_TARGET) begin
         if (sent % 100 < 24 && $urandom_range(0, 3) == 0) add_pct = $urandom_range(20, 80);
         burst = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < ITEM_TARGET; i++) begin
            send_request(pick_action(add_pct), pick_key());
            sent++;
         end
         if (!paused && sent >= ITEM_TARGET / 2) begin
            paused = 1'b1;
            drain_results();
         end else if ($urandom_range(0, 3) != 0) begin
            hold_off($urandom_range(1, 12));
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (sets.pending() != 0)
         sets.report($sformatf("%0d responses never arrived", sets.pending()));
      if (sets.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
